// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSS_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error("lbl");
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("lbl");
`else
`define SSS_ASSERT(lbl, clk, rst_n, expr)
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/sss_pkg.sv
// Shared types and constants of the state-space step block.
// No dependencies.
package sss_pkg;
	localparam int NCELL = 8;
	localparam int NIN = 4;
	localparam int FRAC = 16;
	localparam int ACC_W = 68;
	localparam int DRAIN_CYC = NCELL + 4;

	typedef enum logic [2:0] {
		OP_LOAD_A = 3'd0,
		OP_LOAD_B = 3'd1,
		OP_SET_X  = 3'd2,
		OP_SET_U  = 3'd3,
		OP_STEP   = 3'd4,
		OP_STEP_Z = 3'd5
	} op_t;

	typedef enum logic [0:0] {
		REG_STATES = 1'b0,
		REG_INPUTS = 1'b1
	} reg_t;

	typedef struct packed {
		logic        vld;
		logic        first;
		logic        is_b;
		logic [2:0]  col;
		logic [31:0] val;
	} tok_t;

	typedef struct packed {
		logic        vld;
		logic        is_b;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] val;
	} cwr_t;
endpackage

// File: hw/rtl/sss_cell.sv
// One cell of the chain: holds one row of Ad and Bd, a multiplier and
// an accumulator. Operand items pass through to the next cell. Uses sss_pkg.
module sss_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0]               cell_id,
	input  sss_pkg::cwr_t            wr,
	input  sss_pkg::tok_t            tok_in,
	output sss_pkg::tok_t            tok_out,
	output logic signed [sss_pkg::ACC_W-1:0] acc
);
	import sss_pkg::*;

	logic [31:0] ad_q [NCELL];
	logic [31:0] bd_q [NIN];
	tok_t tok_q;
	logic signed [63:0] prod_s1;
	logic pvld_s1, pfirst_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0] coef;

	always_ff @(posedge clk) begin
		if (wr.vld && wr.row == cell_id) begin
			if (!wr.is_b)
				ad_q[wr.col] <= wr.val;
			else if (!wr.col[2])
				bd_q[wr.col[1:0]] <= wr.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			pvld_s1 <= 1'b0;
			pfirst_s1 <= 1'b0;
		end else begin
			tok_q <= tok_in;
			pvld_s1 <= tok_q.vld;
			pfirst_s1 <= tok_q.first;
		end
	end

	assign coef = tok_q.is_b ? bd_q[tok_q.col[1:0]] : ad_q[tok_q.col];

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(coef) * $signed(tok_q.val);
		if (pvld_s1)
			acc_q <= pfirst_s1 ? ACC_W'(prod_s1) : acc_q + ACC_W'(prod_s1);
	end

	assign tok_out = tok_q;
	assign acc = acc_q;
endmodule

// File: hw/rtl/state_space_step_top.sv
// Top level of the state-space step block: sequencer, state/input
// vectors, rounding and output register. Uses sss_pkg, sss_cell, assert_macros.svh.
//
// channel   dir  handshake         payload
// s_*       in   s_tvalid/s_tready tdata: op, row, col, value
// m_*       out  m_tvalid/m_tready tdata: state_index, state_value; tlast; tuser
// cfg_*     in   cfg_valid/ready   cfg_index, cfg_data
//
// A step issues n+m (or n) operand items, drains them through the cell chain,
// then emits n outputs. Reset clears the state and input vectors; coefficients
// are undefined until written. Output stalls hold the sequencer; input is taken
// only between steps.
`include "assert_macros.svh"
module state_space_step_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // op[2:0], row[5:3], col[8:6], value[40:9]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // state_index[2:0], state_value[34:3]
	output logic        m_tlast,
	output logic [0:0]  m_tuser,   // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import sss_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} st_t;

	st_t st_q;
	logic [3:0] states_q, n_eff, tot_q, cnt_q;
	logic [2:0] inputs_q, m_eff, ecnt_q;
	logic [31:0] x_q [NCELL];
	logic [31:0] u_q [NIN];
	tok_t tok_q;
	tok_t tok_c [NCELL+1];
	logic signed [ACC_W-1:0] acc_c [NCELL];
	cwr_t cwr;
	logic [2:0] in_op, in_row, in_col;
	logic [31:0] in_val;
	logic in_acc;
	logic [3:0] bcol;
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-FRAC-1:0] shr;
	logic ovf, emit;
	logic [31:0] res;
	logic [31:0] x_rd;

	assign in_op = s_tdata[2:0];
	assign in_row = s_tdata[5:3];
	assign in_col = s_tdata[8:6];
	assign in_val = s_tdata[40:9];
	assign s_tready = (st_q == ST_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign n_eff = (states_q == 4'd0) ? 4'd1 :
		(states_q > 4'(NCELL)) ? 4'(NCELL) : states_q;
	assign m_eff = (inputs_q == 3'd0) ? 3'd1 :
		(inputs_q > 3'(NIN)) ? 3'(NIN) : inputs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_q <= 4'(NCELL);
			inputs_q <= 3'(NIN);
		end else if (cfg_valid) begin
			case (cfg_index)
				2'(REG_STATES): states_q <= cfg_data[3:0];
				2'(REG_INPUTS): inputs_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cwr.vld = in_acc && (in_op == OP_LOAD_A || in_op == OP_LOAD_B);
	assign cwr.is_b = (in_op == OP_LOAD_B);
	assign cwr.row = in_row;
	assign cwr.col = in_col;
	assign cwr.val = in_val;

	assign tok_c[0] = tok_q;
	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		sss_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cell_id(3'(g)), .wr(cwr),
			.tok_in(tok_c[g]), .tok_out(tok_c[g+1]), .acc(acc_c[g])
		);
	end

	assign bcol = cnt_q - n_eff;
	assign x_rd = x_q[cnt_q[2:0]];

	assign rnd = acc_c[ecnt_q] + ACC_W'(1 << (FRAC - 1));
	assign shr = rnd[ACC_W-1:FRAC];
	assign ovf = !((&shr[ACC_W-FRAC-1:31]) || !(|shr[ACC_W-FRAC-1:31]));
	assign res = ovf ? (shr[ACC_W-FRAC-1] ? 32'h8000_0000 : 32'h7FFF_FFFF) : shr[31:0];
	assign emit = (st_q == ST_EMIT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			tot_q <= '0;
			ecnt_q <= '0;
			tok_q <= '0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < NCELL; i++) x_q[i] <= '0;
			for (int i = 0; i < NIN; i++) u_q[i] <= '0;
		end else begin
			tok_q.vld <= (st_q == ST_RUN);
			if (emit)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_op == OP_SET_X)
							x_q[in_row] <= in_val;
						if (in_op == OP_SET_U && !in_row[2])
							u_q[in_row[1:0]] <= in_val;
						if (in_op == OP_STEP || in_op == OP_STEP_Z) begin
							tot_q <= n_eff + ((in_op == OP_STEP) ? 4'(m_eff) : 4'd0);
							cnt_q <= '0;
							st_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					tok_q.first <= (cnt_q == 4'd0);
					tok_q.is_b <= (cnt_q >= n_eff);
					tok_q.col <= (cnt_q >= n_eff) ? bcol[2:0] : cnt_q[2:0];
					tok_q.val <= (cnt_q >= n_eff) ? u_q[bcol[1:0]] : x_rd;
					if (cnt_q == tot_q - 4'd1) begin
						cnt_q <= '0;
						st_q <= ST_DRAIN;
					end else
						cnt_q <= cnt_q + 4'd1;
				end
				ST_DRAIN: begin
					if (cnt_q == 4'(DRAIN_CYC - 1)) begin
						ecnt_q <= '0;
						st_q <= ST_EMIT;
					end else
						cnt_q <= cnt_q + 4'd1;
				end
				ST_EMIT: begin
					if (emit) begin
						x_q[ecnt_q] <= res;
						ecnt_q <= ecnt_q + 3'd1;
						if (4'(ecnt_q) == n_eff - 4'd1)
							st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {5'd0, res, ecnt_q};
			m_tlast <= (4'(ecnt_q) == n_eff - 4'd1);
			m_tuser <= ovf;
		end
	end

	`SSS_ASSERT(a_last_idx, clk, arst_n, !(m_tvalid && m_tlast) || 4'(m_tdata[2:0]) == n_eff - 4'd1)
	`SSS_ASSERT(a_idx_rng, clk, arst_n, !m_tvalid || 4'(m_tdata[2:0]) < n_eff)
	`SSS_ASSERT_NEXT(a_step_busy, clk, arst_n, in_acc && (in_op == OP_STEP || in_op == OP_STEP_Z), !s_tready)
endmodule
